[src/mkd_pkg.sv]
// Shared types and fixed constants of the keyframe dimmer.
package mkd_pkg;

    // Field widths of the item and result payloads
    localparam int TIME_W  = 9;
    localparam int LEVEL_W = 7;

    // Interpolation arithmetic
    localparam int DIFF_W        = LEVEL_W + 1;          // level difference, signed
    localparam int DT_W          = TIME_W + 1;           // step time minus point time, signed
    localparam int PROD_W        = DIFF_W + DT_W;        // product, signed
    localparam int SPAN_W        = TIME_W + 1;           // time span, signed
    localparam int NUM_W         = 16;                   // product magnitude, max 127*511
    localparam int DEN_W         = TIME_W;               // span magnitude, max 511
    localparam int BITS_PER_STEP = 2;
    localparam int DIV_STEPS     = NUM_W / BITS_PER_STEP;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

    // Controller to datapath
    typedef struct packed {
        logic load_wr;   // load transaction accepted
        logic tick;      // tick transaction accepted
        logic rd_prev;   // read previous point
        logic rd_next;   // read next point, hold previous
        logic mul;       // multiply, span, index advance
        logic prep;      // set up divider
        logic div_step;  // one divider iteration
        logic emit;      // load the output register
    } mkd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
        logic div_last;  // current divider iteration is the final one
    } mkd_status_t;

endpackage

[src/mkd_in_if.sv]
// Item channel: valid/ready handshake with a tick or load payload.
interface mkd_in_if;
    logic              valid;
    logic              ready;
    logic              op;
    logic [2:0]        load_channel;
    logic [3:0]        point_slot;
    logic signed [8:0] point_time;
    logic [6:0]        point_level;

    modport source (
        output valid, op, load_channel, point_slot, point_time, point_level,
        input  ready
    );
    modport sink (
        input  valid, op, load_channel, point_slot, point_time, point_level,
        output ready
    );
endinterface

[src/mkd_out_if.sv]
// Result channel: valid/ready handshake with one channel level.
interface mkd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] channel;
    logic [6:0] level;
    logic       last;

    modport source (
        output valid, channel, level, last,
        input  ready
    );
    modport sink (
        input  valid, channel, level, last,
        output ready
    );
endinterface

[src/mkd_datapath.sv]
// Datapath: step timing, point table, multiplier, radix-4 divider, output register.
module mkd_datapath
    import mkd_pkg::*;
#(
    parameter int CHANNELS   = 8,
    parameter int MAX_POINTS = 16,
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int PT_W      = $clog2(MAX_POINTS),
    localparam int DEPTH     = CHANNELS * MAX_POINTS,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  mkd_cmd_t            cmd,
    input  logic [CH_W-1:0]     ch,
    input  logic [2:0]          load_channel,
    input  logic [3:0]          point_slot,
    input  logic signed [8:0]   point_time,
    input  logic [6:0]          point_level,
    input  logic [15:0]         step_ticks,
    input  logic [7:0]          cycle_length,
    input  logic [4:0]          points_in_use,
    output mkd_status_t         status,
    mkd_out_if.source           results
);

    localparam int DCNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    typedef struct packed {
        logic [TIME_W-1:0]  pt_time;
        logic [LEVEL_W-1:0] pt_level;
    } point_t;

    // ---------------- step timing ----------------
    logic [15:0]     tick_counter_reg, tick_counter_next, tc_inc;
    logic [7:0]      step_time_reg, step_time_next, st_inc;
    logic            np_reset;
    logic [PT_W-1:0] next_point_reg [CHANNELS];
    logic [PT_W-1:0] np_cur, np_adv;
    logic [PT_W:0]   np_inc;

    always_comb
    begin
        tc_inc            = tick_counter_reg + 16'd1;
        st_inc            = step_time_reg + 8'd1;
        tick_counter_next = tick_counter_reg;
        step_time_next    = step_time_reg;
        np_reset          = 1'b0;
        if (cmd.tick)
        begin
            if (tc_inc >= step_ticks)
            begin
                tick_counter_next = '0;
                if (st_inc >= cycle_length)
                begin
                    step_time_next = '0;
                    np_reset       = 1'b1;
                end
                else
                begin
                    step_time_next = st_inc;
                end
            end
            else
            begin
                tick_counter_next = tc_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_counter_reg <= '0;
            step_time_reg    <= '0;
        end
        else
        begin
            tick_counter_reg <= tick_counter_next;
            step_time_reg    <= step_time_next;
        end
    end

    // ---------------- point table ----------------
    point_t          point_mem [DEPTH];
    point_t          rdata_reg, prev_reg, wr_point;
    logic [AW-1:0]   wr_addr, rd_addr;
    logic            wr_en;
    logic [PT_W-1:0] rd_idx;

    assign np_cur   = next_point_reg[ch];
    assign rd_idx   = cmd.rd_prev ? (np_cur - PT_W'(1)) : np_cur;
    assign rd_addr  = AW'(int'(ch) * MAX_POINTS + int'(rd_idx));
    assign wr_addr  = AW'(int'(load_channel) * MAX_POINTS + int'(point_slot));
    assign wr_en    = cmd.load_wr && (int'(load_channel) < CHANNELS)
                      && (int'(point_slot) < MAX_POINTS);
    assign wr_point = '{pt_time: point_time, pt_level: point_level};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            point_mem[wr_addr] <= wr_point;
        end
        if (cmd.rd_prev || cmd.rd_next)
        begin
            rdata_reg <= point_mem[rd_addr];
        end
        if (cmd.rd_next)
        begin
            prev_reg <= rdata_reg;
        end
    end

    // ---------------- multiply, span, index advance ----------------
    logic signed [DIFF_W-1:0] diff;
    logic signed [DT_W-1:0]   dt;
    logic signed [PROD_W-1:0] prod_next, prod_reg;
    logic signed [SPAN_W-1:0] span_next, span_reg;
    logic [LEVEL_W-1:0]       pp_reg;

    // rdata_reg holds the next point and prev_reg the previous one here
    assign diff      = $signed({1'b0, rdata_reg.pt_level}) - $signed({1'b0, prev_reg.pt_level});
    assign dt        = $signed({2'b00, step_time_reg})
                       - $signed({prev_reg.pt_time[TIME_W-1], prev_reg.pt_time});
    assign prod_next = diff * dt;
    assign span_next = $signed({rdata_reg.pt_time[TIME_W-1], rdata_reg.pt_time})
                       - $signed({prev_reg.pt_time[TIME_W-1], prev_reg.pt_time});

    always_comb
    begin
        np_inc = {1'b0, np_cur} + (PT_W + 1)'(1);
        np_adv = np_cur;
        if ({1'b0, step_time_reg} == rdata_reg.pt_time)
        begin
            if ((int'(np_inc) >= int'(points_in_use)) || (int'(np_inc) >= MAX_POINTS))
            begin
                np_adv = PT_W'(1);
            end
            else
            begin
                np_adv = np_inc[PT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                next_point_reg[c] <= PT_W'(1);
            end
        end
        else if (np_reset)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                next_point_reg[c] <= PT_W'(1);
            end
        end
        else if (cmd.mul)
        begin
            next_point_reg[ch] <= np_adv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
            span_reg <= span_next;
            pp_reg   <= prev_reg.pt_level;
        end
    end

    // ---------------- divider ----------------
    logic [NUM_W-1:0]         num_reg, num_next;
    logic [DEN_W-1:0]         den_reg, rem_reg, rem_next;
    logic                     neg_reg, span_zero_reg;
    logic [DCNT_W-1:0]        div_cnt_reg, div_cnt_next;
    logic signed [PROD_W-1:0] prod_mag;
    logic signed [SPAN_W-1:0] span_mag;

    assign prod_mag = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
    assign span_mag = span_reg[SPAN_W-1] ? -span_reg : span_reg;

    // restoring division, BITS_PER_STEP quotient bits per cycle
    always_comb
    begin
        logic [DEN_W:0] trial;
        rem_next = rem_reg;
        num_next = num_reg;
        for (int i = 0; i < BITS_PER_STEP; i++)
        begin
            trial    = {rem_next, num_next[NUM_W-1]};
            num_next = {num_next[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                trial       = trial - {1'b0, den_reg};
                num_next[0] = 1'b1;
            end
            rem_next = trial[DEN_W-1:0];
        end
    end

    always_comb
    begin
        div_cnt_next = div_cnt_reg;
        if (cmd.prep)
        begin
            div_cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_next = div_cnt_reg + DCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else
        begin
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            num_reg       <= prod_mag[NUM_W-1:0];
            den_reg       <= span_mag[DEN_W-1:0];
            rem_reg       <= '0;
            neg_reg       <= prod_reg[PROD_W-1] ^ span_reg[SPAN_W-1];
            span_zero_reg <= (span_reg == '0);
        end
        else if (cmd.div_step)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    // ---------------- level and output register ----------------
    logic signed [PROD_W-1:0] quo, quo_s, lvl;
    logic [LEVEL_W-1:0]       lvl_sat;
    logic                     out_valid_reg, out_last_reg;
    logic [2:0]               out_channel_reg;
    logic [LEVEL_W-1:0]       out_level_reg;

    assign quo   = $signed({{(PROD_W - NUM_W){1'b0}}, num_reg});
    assign quo_s = neg_reg ? -quo : quo;

    always_comb
    begin
        if (span_zero_reg)
        begin
            lvl = $signed({{(PROD_W - LEVEL_W){1'b0}}, pp_reg});
        end
        else
        begin
            lvl = quo_s + $signed({{(PROD_W - LEVEL_W){1'b0}}, pp_reg});
        end
        if (lvl < 0)
        begin
            lvl_sat = '0;
        end
        else if (lvl > $signed({{(PROD_W - LEVEL_W){1'b0}}, LEVEL_MAX}))
        begin
            lvl_sat = LEVEL_MAX;
        end
        else
        begin
            lvl_sat = lvl[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_channel_reg <= 3'(ch);
            out_level_reg   <= lvl_sat;
            out_last_reg    <= (ch == CH_W'(CHANNELS - 1));
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.channel = out_channel_reg;
    assign results.level   = out_level_reg;
    assign results.last    = out_last_reg;

    assign status.out_free = !out_valid_reg || results.ready;
    assign status.div_last = (div_cnt_reg == DCNT_W'(DIV_STEPS - 1));

    // ---------------- assertions ----------------
    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result loaded while output register still held one");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !results.ready) |=> (out_valid_reg && $stable(out_level_reg)))
        else $error("stalled result changed or vanished");

    a_np_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul |-> (np_cur != '0))
        else $error("channel point index reached zero");

endmodule

[src/mkd_ctrl.sv]
// Controller: sequences load and tick transactions through the datapath, one channel at a time.
module mkd_ctrl
    import mkd_pkg::*;
#(
    parameter int CHANNELS = 8,
    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  logic            item_op,
    output logic            item_ready,
    input  mkd_status_t     status,
    output mkd_cmd_t        cmd,
    output logic [CH_W-1:0] ch
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_RD_PREV = 7'b0000010,
        S_RD_NEXT = 7'b0000100,
        S_MUL     = 7'b0001000,
        S_PREP    = 7'b0010000,
        S_DIV     = 7'b0100000,
        S_FIN     = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    logic [CH_W-1:0] ch_reg, ch_next;
    logic            accept, last_ch;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;
    assign last_ch    = (ch_reg == CH_W'(CHANNELS - 1));

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        ch_next      = ch_reg;
        cmd.load_wr  = accept && item_op;
        cmd.tick     = accept && !item_op;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && !item_op)
                begin
                    ch_next    = '0;
                    state_next = S_RD_PREV;
                end
            end
            S_RD_PREV:
            begin
                cmd.rd_prev = 1'b1;
                state_next  = S_RD_NEXT;
            end
            S_RD_NEXT:
            begin
                cmd.rd_next = 1'b1;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (last_ch)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + CH_W'(1);
                        state_next = S_RD_PREV;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    assign ch = ch_reg;

    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && !item_op) |=> (state_reg == S_RD_PREV && ch_reg == '0))
        else $error("tick transaction did not start the channel sweep");

    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item_op) |=> (state_reg == S_IDLE))
        else $error("load transaction left idle");

    a_div_runs_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && !status.div_last) |=> (state_reg == S_DIV))
        else $error("divider left before its final iteration");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && !status.out_free) |=> (state_reg == S_FIN && $stable(ch_reg)))
        else $error("channel result dropped while output stalled");

endmodule

[src/multichannel_keyframe_dimmer.sv]
// Top level of the multichannel keyframe dimmer: APB registers and channel hookup.
//
// A load transaction writes one (time, level) point into the channel's table and leaves the
// block idle. A tick transaction advances the step timer and then produces one result per
// channel, channel 0 first, with last set on the final one. A tick occupies the block until
// its last result has been loaded into the output register: per channel, two reads through
// the single point-table read port, a multiply, a divider setup, the iterations of the
// two-bit-per-cycle divider and an output step that waits while the result side stalls.
// New transactions are taken only between ticks; the last result of a tick may still wait in
// the output register while the next transaction is accepted. The point table has no reset:
// a point must be loaded before any tick reads it. Registers at byte addresses 0, 4 and 8
// (step_ticks, cycle_length, points_in_use) should be written only while the block is idle.
module multichannel_keyframe_dimmer
    import mkd_pkg::*;
#(
    parameter int CHANNELS   = 8,
    parameter int MAX_POINTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    mkd_in_if.sink      items,
    mkd_out_if.source   results,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [1:0] REG_STEP_TICKS    = 2'd0;
    localparam logic [1:0] REG_CYCLE_LENGTH  = 2'd1;
    localparam logic [1:0] REG_POINTS_IN_USE = 2'd2;

    localparam logic [15:0] STEP_TICKS_RST    = 16'd10;
    localparam logic [7:0]  CYCLE_LENGTH_RST  = 8'd50;
    localparam logic [4:0]  POINTS_IN_USE_RST = 5'd10;

    logic [15:0] step_ticks_reg;
    logic [7:0]  cycle_length_reg;
    logic [4:0]  points_in_use_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_ticks_reg    <= STEP_TICKS_RST;
            cycle_length_reg  <= CYCLE_LENGTH_RST;
            points_in_use_reg <= POINTS_IN_USE_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_STEP_TICKS:    step_ticks_reg    <= pwdata[15:0];
                REG_CYCLE_LENGTH:  cycle_length_reg  <= pwdata[7:0];
                REG_POINTS_IN_USE: points_in_use_reg <= pwdata[4:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_STEP_TICKS:    prdata = {16'd0, step_ticks_reg};
            REG_CYCLE_LENGTH:  prdata = {24'd0, cycle_length_reg};
            REG_POINTS_IN_USE: prdata = {27'd0, points_in_use_reg};
            default:           prdata = '0;
        endcase
    end

    mkd_cmd_t        cmd;
    mkd_status_t     status;
    logic [CH_W-1:0] ch;
    logic            item_ready;

    assign items.ready = item_ready;

    mkd_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (items.valid),
        .item_op    (items.op),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd),
        .ch         (ch)
    );

    mkd_datapath #(
        .CHANNELS   (CHANNELS),
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .ch            (ch),
        .load_channel  (items.load_channel),
        .point_slot    (items.point_slot),
        .point_time    (items.point_time),
        .point_level   (items.point_level),
        .step_ticks    (step_ticks_reg),
        .cycle_length  (cycle_length_reg),
        .points_in_use (points_in_use_reg),
        .status        (status),
        .results       (results)
    );

endmodule

[tb/multichannel_keyframe_dimmer_tb.sv]
// Testbench for the keyframe dimmer: random point loads and ticks checked against a level predictor.
module multichannel_keyframe_dimmer_tb;

    localparam int CHANNELS      = 8;
    localparam int MAX_POINTS    = 16;
    localparam int SETTLE_CYCLES = 120;   // covers one whole tick plus the output register
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;

    typedef enum logic {OP_TICK = 1'b0, OP_LOAD = 1'b1} dimmer_op_e;

    typedef enum logic [3:0]
    {
        REG_STEP_TICKS    = 4'h0,
        REG_CYCLE_LENGTH  = 4'h4,
        REG_POINTS_IN_USE = 4'h8
    } dimmer_reg_e;

    typedef struct {
        dimmer_op_e        op;
        logic [2:0]        ch;
        logic [3:0]        slot;
        logic signed [8:0] tm;
        logic [6:0]        lvl;
    } dimmer_item_t;

    typedef struct {
        logic [2:0] channel;
        logic [6:0] level;
        logic       last;
    } level_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mkd_in_if  item_bus ();
    mkd_out_if result_bus ();

    multichannel_keyframe_dimmer #(
        .CHANNELS   (CHANNELS),
        .MAX_POINTS (MAX_POINTS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_bus),
        .results (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 clk = ~clk;

    // Predictor state
    logic [15:0]       cfg_step_ticks = 16'd10;
    logic [7:0]        cfg_cycle_len  = 8'd50;
    logic [4:0]        cfg_points     = 5'd10;
    logic [15:0]       tick_cnt       = '0;
    logic [7:0]        step_now       = '0;
    logic [3:0]        next_idx [CHANNELS] = '{default: 4'd1};
    logic signed [8:0] pt_time  [CHANNELS*MAX_POINTS];
    logic [6:0]        pt_level [CHANNELS*MAX_POINTS];

    dimmer_item_t  item_backlog [$];
    level_result_t expected_levels [$];
    dimmer_item_t  cur_item;
    level_result_t want;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int stall_cycles  = 0;
    int error_count   = 0;

    task automatic report_error(input string what);
        error_count++;
        $display("ERROR @%0t: %s", $time, what);
    endtask

    // Applies one accepted transaction; a tick queues one level per channel.
    function automatic void advance_dimmer(input dimmer_item_t it);
        int c;
        int n;
        int base;
        int tp;
        int pp;
        int tn;
        int pn;
        int now;
        int span;
        int lvl;
        level_result_t r;
        if (it.op == OP_LOAD)
        begin
            pt_time[{it.ch, it.slot}]  = it.tm;
            pt_level[{it.ch, it.slot}] = it.lvl;
            return;
        end
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= cfg_step_ticks)
        begin
            tick_cnt = '0;
            step_now = step_now + 8'd1;
            if (step_now >= cfg_cycle_len)
            begin
                step_now = '0;
                for (c = 0; c < CHANNELS; c++)
                    next_idx[c] = 4'd1;
            end
        end
        for (c = 0; c < CHANNELS; c++)
        begin
            n = int'(next_idx[c]);
            if (n < 1)
                n = 1;
            base = c * MAX_POINTS;
            tp   = $signed(pt_time[base + n - 1]);
            pp   = int'(pt_level[base + n - 1]);
            tn   = $signed(pt_time[base + n]);
            pn   = int'(pt_level[base + n]);
            now  = int'(step_now);
            if (now == tn)
            begin
                n = n + 1;
                if (n >= int'(cfg_points) || n >= MAX_POINTS)
                    n = 1;
            end
            next_idx[c] = 4'(n);
            span = tn - tp;
            if (span == 0)
                lvl = pp;
            else
                lvl = ((pn - pp) * (now - tp)) / span + pp;
            r.channel = 3'(c);
            r.level   = (lvl < 0) ? 7'd0 : (lvl > 100) ? 7'd100 : 7'(lvl);
            r.last    = (c == CHANNELS - 1);
            expected_levels.push_back(r);
        end
    endfunction

    // Item driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_bus.valid <= 1'b0;
        end
        else
        begin
            if (item_bus.valid && item_bus.ready)
                advance_dimmer(cur_item);
            if (!item_bus.valid || item_bus.ready)
            begin
                if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_item = item_backlog.pop_front();
                    item_bus.valid        <= 1'b1;
                    item_bus.op           <= cur_item.op;
                    item_bus.load_channel <= cur_item.ch;
                    item_bus.point_slot   <= cur_item.slot;
                    item_bus.point_time   <= cur_item.tm;
                    item_bus.point_level  <= cur_item.lvl;
                end
                else
                begin
                    item_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result ready: random stalls, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_bus.ready <= 1'b0;
        end
        else if (hold_request != hold_seen)
        begin
            hold_seen <= hold_request;
            hold_left <= HOLD_CYCLES;
            result_bus.ready <= 1'b0;
        end
        else
        begin
            result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (expected_levels.size() == 0)
            begin
                report_error($sformatf("unexpected result, channel %0d level %0d",
                                       result_bus.channel, result_bus.level));
            end
            else
            begin
                want = expected_levels.pop_front();
                if (result_bus.channel !== want.channel)
                    report_error($sformatf("channel %0d, predicted %0d",
                                           result_bus.channel, want.channel));
                if (result_bus.level !== want.level)
                    report_error($sformatf("channel %0d level %0d, predicted %0d",
                                           want.channel, result_bus.level, want.level));
                if (result_bus.last !== want.last)
                    report_error($sformatf("channel %0d last %0b, predicted %0b",
                                           want.channel, result_bus.last, want.last));
            end
        end
    end

    // Watchdog: cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("multichannel_keyframe_dimmer: mismatch");
                $finish;
            end
        end
    end

    task automatic write_reg(input dimmer_reg_e addr, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            REG_STEP_TICKS:    cfg_step_ticks = value[15:0];
            REG_CYCLE_LENGTH:  cfg_cycle_len  = value[7:0];
            REG_POINTS_IN_USE: cfg_points     = value[4:0];
            default: ;
        endcase
    endtask

    // Waits until the block has taken everything and delivered every level
    task automatic settle();
        while (item_backlog.size() != 0 || item_bus.valid || expected_levels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic void queue_load(input int ch, input int slot, input int tm, input int lvl);
        dimmer_item_t it;
        it.op   = OP_LOAD;
        it.ch   = 3'(ch);
        it.slot = 4'(slot);
        it.tm   = 9'(tm);
        it.lvl  = 7'(lvl);
        item_backlog.push_back(it);
    endfunction

    function automatic void queue_ticks(input int count);
        dimmer_item_t it;
        it.op   = OP_TICK;
        it.ch   = 3'($urandom_range(7));
        it.slot = 4'($urandom_range(15));
        it.tm   = 9'($urandom_range(511));
        it.lvl  = 7'($urandom_range(100));
        repeat (count)
            item_backlog.push_back(it);
    endfunction

    // Rising keyframe times spread over the cycle, now and then a point that is never reached
    function automatic int shape_channel(input int ch, input int lim);
        int s;
        int t;
        int spread;
        t = $urandom_range(2);
        spread = int'(cfg_cycle_len) / lim + 2;
        for (s = 0; s < lim; s++)
        begin
            if ($urandom_range(9) == 0)
                queue_load(ch, s, -1, $urandom_range(100));
            else
                queue_load(ch, s, (t > 255) ? 255 : t, $urandom_range(100));
            t = t + $urandom_range(spread);
        end
        return lim;
    endfunction

    task automatic run_phase(input int step, input int cyc, input int pts, input int count,
                             input int send_pct, input int recv_pct, input bit hold);
        int done;
        int pick;
        int lim;
        int k;
        settle();
        write_reg(REG_STEP_TICKS, 32'(step));
        write_reg(REG_CYCLE_LENGTH, 32'(cyc));
        write_reg(REG_POINTS_IN_USE, 32'(pts));
        @(negedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        lim = (pts < 2) ? 2 : (pts > MAX_POINTS) ? MAX_POINTS : pts;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
            begin
                done += shape_channel($urandom_range(CHANNELS - 1), lim);
            end
            else if (pick < 80)
            begin
                k = $urandom_range(1, 6);
                queue_ticks(k);
                done += k;
            end
            else
            begin
                queue_load($urandom_range(CHANNELS - 1), $urandom_range(MAX_POINTS - 1),
                           int'($urandom_range(256)) - 1, $urandom_range(100));
                done++;
            end
        end
        if (hold)
            hold_request++;
    endtask

    initial
    begin
        int c;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(REG_STEP_TICKS, 32'd1);
        write_reg(REG_CYCLE_LENGTH, 32'd20);
        write_reg(REG_POINTS_IN_USE, 32'd6);
        @(negedge clk);
        send_idle_pct = 34;
        recv_idle_pct = 65;

        // Whole table first, so no tick ever reads an empty point
        for (c = 0; c < CHANNELS; c++)
            void'(shape_channel(c, MAX_POINTS));

        // Directed: ramp, zero span, far-off and never-reached points, falling span
        queue_load(0, 0, 0, 0);
        queue_load(0, 1, 4, 100);
        queue_load(1, 0, 3, 100);
        queue_load(1, 1, 3, 20);
        queue_load(2, 0, 255, 100);
        queue_load(2, 1, 0, 0);
        queue_load(3, 1, 255, 100);
        queue_load(7, 1, -1, 0);
        queue_load(7, 15, -1, 100);
        queue_load(4, 0, 6, 0);
        queue_load(4, 1, 2, 100);
        queue_ticks(12);

        run_phase(1, 20, 6, 30, 34, 65, 1'b1);
        run_phase(3, 12, 16, 30, 34, 65, 1'b0);
        run_phase(65535, 255, 2, 15, 34, 65, 1'b0);
        run_phase(0, 0, 1, 30, 65, 34, 1'b0);
        run_phase(1, 255, 0, 30, 65, 34, 1'b0);
        run_phase(2, 1, 31, 30, 0, 0, 1'b0);
        run_phase(1, 40, 16, 30, 0, 0, 1'b0);
        run_phase(5, 8, 9, 30, 0, 0, 1'b0);
        settle();

        if (error_count == 0)
            $display("multichannel_keyframe_dimmer: match");
        else
            $display("multichannel_keyframe_dimmer: mismatch");
        $finish;
    end

endmodule
